@@ sv/lzwc_pkg.sv @@
// ----------------------------------------------------------------------------
// lzwc_pkg
// Types and fixed constants shared by the LZW stream compressor files.
// ----------------------------------------------------------------------------
package lzwc_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       stream_end;
    } t_out_item;

    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       flush;
        logic       flush_end;
    } t_push_ctl;

    localparam int         CODE_CLEAR = 256;
    localparam int         FIRST_FREE = 257;
    localparam logic [4:0] MIN_WIDTH  = 5'd9;
    localparam logic [7:0] HDR_MAGIC0 = 8'h1F;
    localparam logic [7:0] HDR_MAGIC1 = 8'h9D;
    localparam logic [7:0] HDR_FLAG   = 8'h80;

endpackage

@@ sv/lzwc_out_stage.sv @@
// ----------------------------------------------------------------------------
// lzwc_out_stage
// Holds the newest output byte until it is known whether another byte of the
// same item follows, then moves it into the output register with its flags.
// ----------------------------------------------------------------------------
module lzwc_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lzwc_pkg::t_push_ctl i_ctl,
    output logic                o_ready,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lzwc_pkg::t_out_item o_out_data
);
    import lzwc_pkg::*;

    logic       r_hold_v;
    logic [7:0] r_hold_b;
    logic       r_out_v;
    t_out_item  r_out;
    logic       w_out_free;

    assign w_out_free  = !r_out_v || !i_out_stall;
    assign o_ready     = !r_hold_v || w_out_free;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (w_out_free) begin
                r_out_v <= 1'b0;
            end
            if (i_ctl.push && o_ready) begin
                r_hold_v <= 1'b1;
                if (r_hold_v) begin
                    r_out_v <= 1'b1;
                end
            end else if (i_ctl.flush && r_hold_v && w_out_free) begin
                r_hold_v <= 1'b0;
                r_out_v  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push && o_ready) begin
            r_hold_b <= i_ctl.push_byte;
            if (r_hold_v) begin
                r_out <= '{out_byte: r_hold_b, last_of_run: 1'b0, stream_end: 1'b0};
            end
        end else if (i_ctl.flush && r_hold_v && w_out_free) begin
            r_out <= '{out_byte: r_hold_b, last_of_run: 1'b1, stream_end: i_ctl.flush_end};
        end
    end

    a_push_only_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.push && r_hold_v && !w_out_free) |=> $stable(r_hold_b))
        else $error("held byte overwritten while output was blocked");
    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.flush && !i_ctl.push && w_out_free) |=> !r_hold_v)
        else $error("flush left a byte in the hold register");
    a_out_after_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_v)) |-> $past(r_hold_v))
        else $error("output byte appeared without a held byte");

endmodule

@@ sv/lzw_stream_compressor.sv @@
// ----------------------------------------------------------------------------
// lzw_stream_compressor
// LZW compressor writing the .Z container. Dictionary entries live in a code
// memory; a hash memory with linear probing maps (prefix, byte) to a code.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// in        input      i_in_valid/o_in_stall  i_in_data  (t_in_item)
// out       output     o_out_valid/i_out_stall o_out_data (t_out_item)
// cfg       input      i_cfg_valid/o_cfg_ready i_cfg_data (max_code_bits)
//
// One item is taken at a time, only in the idle state. A first item of a
// stream sends the 3 header bytes, then passes through finish, release of
// the last byte and idle. Other items pass through the lookup states LK0,
// LK1 and LK2 once per hash probe, then the same finish, release and idle;
// each code sent goes through load and drain, which pushes out whole bytes.
// A last item also loads and drains its final code. Reset is synchronous
// and starts a clearing pass over all 2^(MAX_BITS+1) hash memory entries,
// with the input stalled. Output stalls hold the sequencer.
// ----------------------------------------------------------------------------
module lzw_stream_compressor #(
    parameter int MAX_BITS = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lzwc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lzwc_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [3:0]          i_cfg_data
);
    import lzwc_pkg::*;

    localparam int CW  = MAX_BITS;
    localparam int NFW = MAX_BITS + 1;
    localparam int HB  = MAX_BITS + 1;
    localparam int AW  = MAX_BITS + 7;
    localparam int DW  = CW + 8 + HB;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HDR   = 4'd1;
    localparam logic [3:0] S_LK0   = 4'd2;
    localparam logic [3:0] S_LK1   = 4'd3;
    localparam logic [3:0] S_LK2   = 4'd4;
    localparam logic [3:0] S_LOAD  = 4'd5;
    localparam logic [3:0] S_DRAIN = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_FLUSH = 4'd8;
    localparam logic [3:0] S_CLR   = 4'd9;

    logic [3:0]    r_state;
    logic [3:0]    r_max;
    logic          r_started;
    logic [CW-1:0] r_cur;
    logic [NFW-1:0] r_nf;
    logic [4:0]    r_cw;
    logic [AW-1:0] r_acc;
    logic [4:0]    r_cnt;
    logic [1:0]    r_hcnt;
    logic          r_pclr;
    logic          r_fdone;
    logic [7:0]    r_byte;
    logic          r_last;
    logic [4:0]    r_m;
    logic [HB-1:0] r_slot;
    logic [CW-1:0] r_c;
    logic [CW-1:0] r_code;
    logic [4:0]    r_w;
    logic [HB-1:0] r_clr;

    logic [DW-1:0] r_dict [2**CW];
    logic [CW-1:0] r_hash [2**HB];
    logic [CW-1:0] r_hash_q;
    logic [DW-1:0] r_dict_q;

    t_push_ctl     w_ctl;
    logic          w_rdy;
    logic          w_accept;
    logic [4:0]    w_m;
    logic [HB-1:0] w_slot;
    logic [CW-1:0] w_dpre;
    logic [7:0]    w_dsuf;
    logic [HB-1:0] w_dslot;
    logic          w_in_range;
    logic          w_own;
    logic          w_match;
    logic          w_at_lim;
    logic          w_grow;
    logic          w_ins;
    logic [7:0]    w_hdr_b;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !o_in_stall;

    always_comb begin
        if (r_max < 4'(MIN_WIDTH)) begin
            w_m = MIN_WIDTH;
        end else if (32'(r_max) > MAX_BITS) begin
            w_m = 5'(MAX_BITS);
        end else begin
            w_m = {1'b0, r_max};
        end
    end

    assign w_slot  = HB'(r_cur) ^ (HB'(i_in_data.data_byte) << (HB - 8));
    assign w_dpre  = r_dict_q[DW-1 -: CW];
    assign w_dsuf  = r_dict_q[HB+7 -: 8];
    assign w_dslot = r_dict_q[HB-1:0];
    assign w_in_range = (r_c >= CW'(FIRST_FREE)) && (NFW'(r_c) < r_nf);
    assign w_own   = (w_dslot == r_slot);
    assign w_match = w_own && (w_dpre == r_cur) && (w_dsuf == r_byte);
    assign w_at_lim = (r_nf == (NFW'(1) << r_cw));
    assign w_grow  = w_at_lim && (r_cw < r_m);
    assign w_ins   = (r_state == S_LK2) && !(w_in_range && w_own) && !(w_at_lim && !w_grow);

    always_comb begin
        unique case (r_hcnt)
            2'd0:    w_hdr_b = HDR_MAGIC0;
            2'd1:    w_hdr_b = HDR_MAGIC1;
            default: w_hdr_b = HDR_FLAG | {3'd0, r_m};
        endcase
    end

    always_comb begin
        w_ctl = '0;
        priority case (r_state)
            S_HDR: begin
                w_ctl.push      = 1'b1;
                w_ctl.push_byte = w_hdr_b;
            end
            S_DRAIN: begin
                w_ctl.push      = (r_cnt >= 5'd8);
                w_ctl.push_byte = r_acc[7:0];
            end
            S_FIN: begin
                w_ctl.push      = r_last && r_fdone && (r_cnt != 5'd0);
                w_ctl.push_byte = r_acc[7:0];
            end
            S_FLUSH: begin
                w_ctl.flush     = 1'b1;
                w_ctl.flush_end = r_last;
            end
            default: begin
            end
        endcase
    end

    lzwc_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .o_ready     (w_rdy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always_ff @(posedge i_clk) begin
        r_hash_q <= r_hash[r_slot];
        r_dict_q <= r_dict[r_hash_q];
        if (r_state == S_CLR) begin
            r_hash[r_clr] <= '0;
        end else if (w_ins) begin
            r_hash[r_slot]      <= r_nf[CW-1:0];
            r_dict[r_nf[CW-1:0]] <= {r_cur, r_byte, r_slot};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_max     <= 4'd9;
            r_started <= 1'b0;
            r_cur     <= '0;
            r_nf      <= NFW'(FIRST_FREE);
            r_cw      <= MIN_WIDTH;
            r_acc     <= '0;
            r_cnt     <= '0;
            r_hcnt    <= '0;
            r_pclr    <= 1'b0;
            r_fdone   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max <= i_cfg_data;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + HB'(1);
                    if (&r_clr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_hcnt  <= '0;
                        r_pclr  <= 1'b0;
                        r_fdone <= 1'b0;
                        r_state <= r_started ? S_LK0 : S_HDR;
                    end
                end
                S_HDR: begin
                    if (w_rdy) begin
                        r_hcnt <= r_hcnt + 2'd1;
                        if (r_hcnt == 2'd2) begin
                            r_started <= 1'b1;
                            r_cur     <= CW'(r_byte);
                            r_state   <= S_FIN;
                        end
                    end
                end
                S_LK0: r_state <= S_LK1;
                S_LK1: r_state <= S_LK2;
                S_LK2: begin
                    if (w_in_range && w_match) begin
                        r_cur   <= r_c;
                        r_state <= S_FIN;
                    end else if (w_in_range && w_own) begin
                        r_state <= S_LK0;
                    end else begin
                        r_code <= r_cur;
                        r_cur  <= CW'(r_byte);
                        if (w_at_lim && !w_grow) begin
                            r_w    <= r_cw;
                            r_pclr <= 1'b1;
                            r_nf   <= NFW'(FIRST_FREE);
                            r_cw   <= MIN_WIDTH;
                        end else begin
                            r_w  <= w_grow ? r_cw + 5'd1 : r_cw;
                            r_cw <= w_grow ? r_cw + 5'd1 : r_cw;
                            r_nf <= r_nf + NFW'(1);
                        end
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_acc   <= r_acc | (AW'(r_code) << r_cnt);
                    r_cnt   <= r_cnt + r_w;
                    r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (r_cnt >= 5'd8) begin
                        if (w_rdy) begin
                            r_acc <= r_acc >> 8;
                            r_cnt <= r_cnt - 5'd8;
                        end
                    end else if (r_pclr) begin
                        r_pclr  <= 1'b0;
                        r_code  <= CW'(CODE_CLEAR);
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_last) begin
                        r_state <= S_FLUSH;
                    end else if (!r_fdone) begin
                        r_fdone <= 1'b1;
                        r_code  <= r_cur;
                        r_w     <= r_cw;
                        r_state <= S_LOAD;
                    end else if (r_cnt == 5'd0 || w_rdy) begin
                        r_started <= 1'b0;
                        r_cur     <= '0;
                        r_nf      <= NFW'(FIRST_FREE);
                        r_cw      <= MIN_WIDTH;
                        r_acc     <= '0;
                        r_cnt     <= '0;
                        r_state   <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    if (w_rdy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_in_data.data_byte;
            r_last <= i_in_data.last_byte;
            r_m    <= w_m;
            r_slot <= w_slot;
        end else if (r_state == S_LK2 && w_in_range && w_own && !w_match) begin
            r_slot <= r_slot + HB'(1);
        end
        if (r_state == S_LK1) begin
            r_c <= r_hash_q;
        end
    end

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_cnt < 5'd8))
        else $error("whole byte left in the bit accumulator");
    a_nf_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nf <= (NFW'(1) << MAX_BITS))
        else $error("next free code beyond dictionary depth");
    a_cw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cw >= MIN_WIDTH) && (32'(r_cw) <= MAX_BITS))
        else $error("code width out of range");
    a_ins_below_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins |-> (r_nf < (NFW'(1) << MAX_BITS)))
        else $error("insert beyond dictionary depth");

endmodule
